// ----- rtl/pfwrl_pkg.sv -----
// Shared types and constants for the per-flow window rate limiter.
// No dependencies; pfwrl_cam and the top level refer to this package.
`default_nettype none

package pfwrl_pkg;

	localparam int KEY_W  = 56;
	localparam int SEC_W  = 35;
	localparam int CNT_W  = 32;
	localparam int ADDR_W = 32;
	localparam int PORT_W = 16;
	localparam int PROT_W = 8;

	// Input beat: address, port, protocol, seconds, padded to 96 bits.
	localparam int IN_DATA_W  = 96;
	// Output beat: exceeded, count, insert failure, padded to 40 bits.
	localparam int OUT_DATA_W = 40;

	typedef logic [KEY_W-1:0] key_t;
	typedef logic [SEC_W-1:0] sec_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// Lookup status reported by the flow table.
	typedef struct packed {
		logic hit;
		logic full;
	} cam_status_t;

	// Count and window second kept together in one memory word.
	typedef struct packed {
		sec_t second;
		cnt_t count;
	} entry_t;

endpackage

`default_nettype wire

// ----- rtl/pfwrl_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module pfwrl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire                                  clk,
	input  wire                                  we,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire  [WIDTH-1:0]                     wdata,
	input  wire                                  re,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/pfwrl_cam.sv -----
// Flow key table: valid bits, stored keys, parallel compare and the
// priority encoders for the matching and the lowest free entry. Uses pfwrl_pkg.
`default_nettype none

module pfwrl_cam #(
	parameter int ENTRIES = 64,
	parameter int IDX_W   = 6
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire  pfwrl_pkg::key_t    lookup_key,
	output logic [IDX_W-1:0]         hit_idx,
	output logic [IDX_W-1:0]         free_idx,
	output pfwrl_pkg::cam_status_t   status,
	input  wire                      ins_en,
	input  wire  [IDX_W-1:0]         ins_idx,
	input  wire  pfwrl_pkg::key_t    ins_key
);

	logic [ENTRIES-1:0] valid_q;
	pfwrl_pkg::key_t    key_q [ENTRIES];
	logic [ENTRIES-1:0] match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ins_en) begin
			valid_q[ins_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ins_en) begin
			key_q[ins_idx] <= ins_key;
		end
	end

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = valid_q[i] && (key_q[i] == lookup_key);
		end
	end

	// Scanning from the top down leaves the lowest set index in place.
	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_idx = IDX_W'(i);
			end
			if (!valid_q[i]) begin
				free_idx = IDX_W'(i);
			end
		end
		status.hit  = |match;
		status.full = &valid_q;
	end

endmodule

`default_nettype wire

// ----- rtl/per_flow_window_rate_limiter_core.sv -----
// Top level of the per-flow fixed-window rate limiter.
// Uses pfwrl_pkg, pfwrl_cam and pfwrl_ram.
//
// Each request beat names a flow (address, port, protocol) and the current
// second. One result beat comes back per request, in order. A new request is
// not taken until the previous one leaves the table path, as only one request
// is in it at a time. In the first stage the key is compared against every
// table entry at once and the read of the matching entry's count and second
// from the table memory is started. In the second stage that entry is updated
// unless refused, or a free entry is filled for a new flow, and the result
// register is loaded. A stalled result beat holds the second stage until the
// result register drains. The flow table needs no clearing pass after reset.
// A rate limit of zero disables the check and leaves the table unchanged.
// The user must write the limit only while idle; the block does not check it.
`default_nettype none

module per_flow_window_rate_limiter_core #(
	parameter int FLOW_ENTRIES = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	// rate_limit register
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [31:0] cfg_data,
	// [31:0] dest_address, [47:32] dest_port, [55:48] protocol,
	// [90:56] now_seconds, [95:91] zero
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [95:0] s_tdata,
	// [0] exceeded, [32:1] flow_count, [33] insert_failed, [39:34] zero
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata
);

	localparam int IDX_W   = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
	localparam int ENTRY_W = pfwrl_pkg::SEC_W + pfwrl_pkg::CNT_W;

	pfwrl_pkg::cnt_t        rate_limit_q;

	logic                   valid_s1;
	pfwrl_pkg::key_t        key_s1;
	pfwrl_pkg::sec_t        now_s1;

	logic                   valid_s2;
	pfwrl_pkg::key_t        key_s2;
	pfwrl_pkg::sec_t        now_s2;
	pfwrl_pkg::cam_status_t status_s2;
	logic [IDX_W-1:0]       hit_idx_s2;
	logic [IDX_W-1:0]       free_idx_s2;

	logic                   out_valid_q;
	logic                   exceeded_q;
	pfwrl_pkg::cnt_t        flow_count_q;
	logic                   insert_failed_q;

	logic [IDX_W-1:0]       hit_idx;
	logic [IDX_W-1:0]       free_idx;
	pfwrl_pkg::cam_status_t status;

	pfwrl_pkg::entry_t      rd_entry;
	pfwrl_pkg::entry_t      wr_entry;
	logic [ENTRY_W-1:0]     rd_word;

	logic                   out_free;
	logic                   s2_done;
	logic                   disabled;
	logic                   same_sec;
	logic                   refuse;
	logic                   do_update;
	logic                   do_insert;
	pfwrl_pkg::cnt_t        new_count;
	logic                   res_exceeded;
	pfwrl_pkg::cnt_t        res_count;
	logic                   res_failed;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_limit_q <= '0;
		end else if (cfg_valid) begin
			rate_limit_q <= cfg_data;
		end
	end

	assign out_free = !out_valid_q || m_tready;
	assign s2_done  = valid_s2 && out_free;
	// Only one request is in the table path at a time, so the next lookup
	// always sees the previous request's update.
	assign s_tready = !valid_s1 && (!valid_s2 || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= s_tvalid && s_tready;
			if (valid_s1) begin
				valid_s2 <= 1'b1;
			end else if (s2_done) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			key_s1 <= {s_tdata[31:0], s_tdata[47:32], s_tdata[55:48]};
			now_s1 <= s_tdata[90:56];
		end
		if (valid_s1) begin
			key_s2      <= key_s1;
			now_s2      <= now_s1;
			status_s2   <= status;
			hit_idx_s2  <= hit_idx;
			free_idx_s2 <= free_idx;
		end
	end

	pfwrl_cam #(
		.ENTRIES (FLOW_ENTRIES),
		.IDX_W   (IDX_W)
	) u_cam (
		.clk        (clk),
		.arst_n     (arst_n),
		.lookup_key (key_s1),
		.hit_idx    (hit_idx),
		.free_idx   (free_idx),
		.status     (status),
		.ins_en     (do_insert),
		.ins_idx    (free_idx_s2),
		.ins_key    (key_s2)
	);

	pfwrl_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (FLOW_ENTRIES)
	) u_entry_ram (
		.clk   (clk),
		.we    (do_update || do_insert),
		.waddr (status_s2.hit ? hit_idx_s2 : free_idx_s2),
		.wdata (wr_entry),
		.re    (valid_s1),
		.raddr (hit_idx),
		.rdata (rd_word)
	);

	assign rd_entry = rd_word;

	// A lowered limit can leave a stored count above it; that refuses too.
	always_comb begin
		disabled  = (rate_limit_q == '0);
		same_sec  = (rd_entry.second == now_s2);
		refuse    = status_s2.hit && same_sec && (rd_entry.count >= rate_limit_q);
		new_count = same_sec ? rd_entry.count + 1'b1 : pfwrl_pkg::cnt_t'(1);
		do_update = s2_done && !disabled && status_s2.hit && !refuse;
		do_insert = s2_done && !disabled && !status_s2.hit && !status_s2.full;
		wr_entry.second = now_s2;
		wr_entry.count  = status_s2.hit ? new_count : pfwrl_pkg::cnt_t'(1);

		res_exceeded = 1'b0;
		res_count    = '0;
		res_failed   = 1'b0;
		priority if (disabled) begin
			res_count = '0;
		end else if (status_s2.hit) begin
			res_exceeded = refuse;
			res_count    = refuse ? rd_entry.count : new_count;
		end else if (status_s2.full) begin
			res_failed = 1'b1;
		end else begin
			res_count = pfwrl_pkg::cnt_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_done) begin
			exceeded_q      <= res_exceeded;
			flow_count_q    <= res_count;
			insert_failed_q <= res_failed;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, insert_failed_q, flow_count_q, exceeded_q};

endmodule

`default_nettype wire

// ----- rtl/pfwrl_checker.sv -----
// Port-level checks for the per-flow window rate limiter, bound to its top.
// No package dependencies; sees only the top level's ports.
`default_nettype none

module pfwrl_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [39:0] m_tdata
);

	// Requests taken whose result beat has not yet been taken.
	logic [1:0] pending_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = s_tvalid && s_tready;
	assign out_beat = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_beat && !out_beat) begin
			pending_q <= pending_q + 2'd1;
		end else if (out_beat && !in_beat) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pending_q != 2'd0)
		else $error("result beat without a pending request");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more than two requests outstanding");

	a_result_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[33])
			&& (!m_tdata[0] || m_tdata[32:1] != 32'd0)
			&& (!m_tdata[33] || m_tdata[32:1] == 32'd0))
		else $error("inconsistent result fields");

endmodule

bind per_flow_window_rate_limiter_core pfwrl_checker u_pfwrl_checker (.*);

`default_nettype wire
